FILE: rtl/fssd_pkg.sv
// Package for the frame sum-of-squared-differences block.
// Holds widths, luma weights, queue sizing and the term entry type.
// No dependencies; every other RTL file imports it.
`default_nettype none

package fssd_pkg;

	localparam int PIX_W   = 8;
	localparam int WGT_W   = 16;
	localparam int LUMA_W  = 24;
	localparam int SQ_W    = 2 * PIX_W;
	localparam int SQSUM_W = SQ_W + 2;
	localparam int FRAC_W  = 8;
	localparam int TERM_W  = SQSUM_W + FRAC_W;
	localparam int PROD_W  = 2 * LUMA_W;
	localparam int TOTAL_W = 48;

	localparam logic [WGT_W-1:0] W_RED   = 16'd19595;
	localparam logic [WGT_W-1:0] W_GREEN = 16'd38470;
	localparam logic [WGT_W-1:0] W_BLUE  = 16'd7471;

	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic              last;
		logic [TERM_W-1:0] term;
	} term_entry_t;

	function automatic logic [LUMA_W-1:0] luma(
		input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] r
	);
		logic [LUMA_W-1:0] yr;
		logic [LUMA_W-1:0] yg;
		logic [LUMA_W-1:0] yb;
		yr = LUMA_W'(W_RED) * LUMA_W'(r);
		yg = LUMA_W'(W_GREEN) * LUMA_W'(g);
		yb = LUMA_W'(W_BLUE) * LUMA_W'(b);
		return yr + yg + yb;
	endfunction

	function automatic logic [PIX_W-1:0] abs_diff8(
		input logic [PIX_W-1:0] x,
		input logic [PIX_W-1:0] y
	);
		return (x >= y) ? (x - y) : (y - x);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/fssd_front.sv
// Front end: accepts pixel pairs and turns each into one accumulation term.
// Four-stage pipeline that always advances; entry is limited by a reservation count.
// Depends on fssd_pkg.
`default_nettype none

module fssd_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 luminance_mode,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           a_blue,
	input  wire logic [7:0]           a_green,
	input  wire logic [7:0]           a_red,
	input  wire logic [7:0]           b_blue,
	input  wire logic [7:0]           b_green,
	input  wire logic [7:0]           b_red,
	input  wire logic                 last_pixel,
	input  wire logic                 q_pop,
	output logic                      push_valid,
	output fssd_pkg::term_entry_t     push_entry
);
	import fssd_pkg::*;

	logic accept;
	logic [QCNT_W-1:0] resv_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic mode_s1, mode_s2, mode_s3;
	logic last_s1, last_s2, last_s3, last_s4;
	logic [PIX_W-1:0] ab_s1, ag_s1, ar_s1, bb_s1, bg_s1, br_s1;
	logic [LUMA_W-1:0] ya_s2, yb_s2;
	logic [PIX_W-1:0] db_s2, dg_s2, dr_s2;
	logic [LUMA_W-1:0] dy_s3;
	logic [SQ_W-1:0] sb_s3, sg_s3, sr_s3;
	logic [TERM_W-1:0] term_s4;

	logic [PROD_W-1:0] dy_prod;
	logic [SQSUM_W-1:0] sq_sum;

	// Every accepted item holds a queue slot from acceptance until it is popped.
	assign in_stall = (resv_q == QCNT_W'(QDEPTH));
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_q <= '0;
		end else begin
			case ({accept, q_pop})
				2'b10:   resv_q <= resv_q + 1'b1;
				2'b01:   resv_q <= resv_q - 1'b1;
				default: resv_q <= resv_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		ab_s1   <= a_blue;
		ag_s1   <= a_green;
		ar_s1   <= a_red;
		bb_s1   <= b_blue;
		bg_s1   <= b_green;
		br_s1   <= b_red;
		last_s1 <= last_pixel;
		mode_s1 <= luminance_mode;

		ya_s2   <= luma(ab_s1, ag_s1, ar_s1);
		yb_s2   <= luma(bb_s1, bg_s1, br_s1);
		db_s2   <= abs_diff8(ab_s1, bb_s1);
		dg_s2   <= abs_diff8(ag_s1, bg_s1);
		dr_s2   <= abs_diff8(ar_s1, br_s1);
		last_s2 <= last_s1;
		mode_s2 <= mode_s1;

		dy_s3   <= (ya_s2 >= yb_s2) ? (ya_s2 - yb_s2) : (yb_s2 - ya_s2);
		sb_s3   <= SQ_W'(db_s2) * SQ_W'(db_s2);
		sg_s3   <= SQ_W'(dg_s2) * SQ_W'(dg_s2);
		sr_s3   <= SQ_W'(dr_s2) * SQ_W'(dr_s2);
		last_s3 <= last_s2;
		mode_s3 <= mode_s2;

		term_s4 <= mode_s3 ? TERM_W'(dy_prod[PROD_W-1:LUMA_W]) : {sq_sum, {FRAC_W{1'b0}}};
		last_s4 <= last_s3;
	end

	assign dy_prod = PROD_W'(dy_s3) * PROD_W'(dy_s3);
	assign sq_sum  = SQSUM_W'(sb_s3) + SQSUM_W'(sg_s3) + SQSUM_W'(sr_s3);

	assign push_valid      = valid_s4;
	assign push_entry.last = last_s4;
	assign push_entry.term = term_s4;

	a_resv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		resv_q <= QCNT_W'(QDEPTH))
		else $error("front reservation count beyond queue depth");

	a_push_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (resv_q != '0))
		else $error("term pushed without a reserved queue slot");

endmodule

`default_nettype wire

FILE: rtl/fssd_queue.sv
// Short queue of terms between the front end and the accumulator.
// Register-array FIFO; space is guaranteed by the front end's reservation count.
// Depends on fssd_pkg.
`default_nettype none

module fssd_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push_valid,
	input  wire fssd_pkg::term_entry_t push_entry,
	input  wire logic                  pop,
	output logic                       not_empty,
	output fssd_pkg::term_entry_t      head
);
	import fssd_pkg::*;

	term_entry_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push_valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (count_q != QCNT_W'(QDEPTH)) || pop)
		else $error("term queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("term queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/fssd_back.sv
// Back end: adds queued terms into the saturating frame total and emits it on the last pixel.
// Holds the running total and the output register.
// Depends on fssd_pkg.
`default_nettype none

module fssd_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  not_empty,
	input  wire fssd_pkg::term_entry_t head,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [47:0]                distance
);
	import fssd_pkg::*;

	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] dist_q;
	logic               out_valid_q;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] sum_sat;
	logic               slot_free;

	// A frame's last term needs the output register; other terms never wait.
	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = not_empty && (!head.last || slot_free);

	assign sum     = {1'b0, total_q} + (TOTAL_W + 1)'(head.term);
	assign sum_sat = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				total_q <= head.last ? '0 : sum_sat;
			end
			if (pop && head.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			dist_q <= sum_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = dist_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |=> (total_q == '0) && out_valid)
		else $error("total not cleared or result not raised after last pixel");

endmodule

`default_nettype wire

FILE: rtl/frame_sum_squared_difference.sv
// Top level of the frame sum-of-squared-differences block.
// Instantiates fssd_front, fssd_queue and fssd_back; holds the mode register.
// Depends on fssd_pkg.
`default_nettype none

// The block compares two frames pixel by pixel and reports one distance per
// frame. Each input transfer carries a co-located BGR pixel pair and a
// last_pixel flag; the transfer that carries last_pixel produces one output
// transfer with the saturating 48-bit total (8 fractional bits) including that
// pixel, and the accumulator starts again from zero. With luminance_mode at 0
// each term is the sum of squared channel differences times 256; with it at 1
// the term is the squared difference of Q8.16 luma values, truncated to 8
// fractional bits. The mode is sampled when a pixel is accepted. The block
// takes one pixel pair per clock in steady state: a four-stage front end
// computes terms and feeds an eight-entry queue, and the accumulator drains
// one term per clock unless a frame's last term waits for the output register.
// Input stall rises only when the eight queue slots are all reserved, which
// happens when a finished result sits stalled on the output. A pixel pair's
// term passes the four front-end stages and the queue before it is added to
// the total, and out_valid is set at the same edge that adds the last pixel's
// term. The mode register accepts a write in every cycle; since the mode
// travels with each pixel, a write applies from the next accepted pixel on,
// also in the middle of a frame.
module frame_sum_squared_difference (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  a_blue,
	input  wire logic [7:0]  a_green,
	input  wire logic [7:0]  a_red,
	input  wire logic [7:0]  b_blue,
	input  wire logic [7:0]  b_green,
	input  wire logic [7:0]  b_red,
	input  wire logic        last_pixel,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [47:0]      distance
);
	import fssd_pkg::*;

	logic        luminance_mode_q;
	logic        push_valid;
	term_entry_t push_entry;
	term_entry_t head;
	logic        not_empty;
	logic        pop;

	// The configuration register is always ready for a transfer.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luminance_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			luminance_mode_q <= cfg_data;
		end
	end

	fssd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.luminance_mode (luminance_mode_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.a_blue         (a_blue),
		.a_green        (a_green),
		.a_red          (a_red),
		.b_blue         (b_blue),
		.b_green        (b_green),
		.b_red          (b_red),
		.last_pixel     (last_pixel),
		.q_pop          (pop),
		.push_valid     (push_valid),
		.push_entry     (push_entry)
	);

	// The queue lets the front end keep accepting while a result waits.
	fssd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	fssd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.distance  (distance)
	);

endmodule

`default_nettype wire

FILE: tb/sv/tb_frame_sum_squared_difference.sv
// Self-checking testbench for frame_sum_squared_difference: directed and random
// frames in both compare modes, random idling on both channels, per-frame checks.
// Depends on fssd_pkg and the frame_sum_squared_difference RTL.
`timescale 1ns / 1ps

module tb_frame_sum_squared_difference;

	import fssd_pkg::*;

	// Settings of the one-bit mode register.
	localparam bit MODE_RGB  = 1'b0;
	localparam bit MODE_LUMA = 1'b1;

	localparam logic [63:0] DISTANCE_MAX = 64'h0000_FFFF_FFFF_FFFF;

	// A pixel pair passes the front-end stages and the queue before it reaches the
	// accumulator, so this many quiet clocks after the last result mean nothing is in flight.
	localparam int SETTLE_CYCLES = 16;

	// The longest correct stretch without any transfer is made up of a sender gap,
	// a receiver stall, the pipeline and the settle pause; allow far more.
	localparam int WATCHDOG_LIMIT = 2000;

	localparam int RANDOM_PAIRS = 1200;

	typedef struct packed {
		logic [7:0] a_blue;
		logic [7:0] a_green;
		logic [7:0] a_red;
		logic [7:0] b_blue;
		logic [7:0] b_green;
		logic [7:0] b_red;
		logic       last;
	} pixel_pair_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  a_blue;
	logic [7:0]  a_green;
	logic [7:0]  a_red;
	logic [7:0]  b_blue;
	logic [7:0]  b_green;
	logic [7:0]  b_red;
	logic        last_pixel;
	logic        out_valid;
	logic        out_stall;
	logic [47:0] distance;

	// Our own copy of the block's state: the compare mode and the frame total.
	bit          luma_selected;
	logic [63:0] frame_total;

	// Distances the block owes us, oldest first.
	logic [47:0] expected_distances[$];
	logic [47:0] wanted_distance;

	// When set, neither side inserts idle cycles, so the block runs at full rate.
	bit no_idle;

	int unsigned pairs_sent;
	int unsigned frames_sent;
	int unsigned luma_frames;
	int unsigned distances_checked;
	int unsigned error_count;
	int unsigned quiet_cycles;

	frame_sum_squared_difference i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.a_blue     (a_blue),
		.a_green    (a_green),
		.a_red      (a_red),
		.b_blue     (b_blue),
		.b_green    (b_green),
		.b_red      (b_red),
		.last_pixel (last_pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.distance   (distance)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Term that one pixel pair adds to the frame total, 8 fractional bits.
	// In luma mode both lumas are Q8.16 and the squared difference is Q16.32,
	// so dropping 24 bits leaves Q16.8, truncated toward zero.
	function automatic logic [63:0] pair_term(input pixel_pair_t p, input bit luma);
		logic [63:0] luma_a;
		logic [63:0] luma_b;
		logic [63:0] luma_diff;
		logic [63:0] db;
		logic [63:0] dg;
		logic [63:0] dr;
		if (luma == MODE_LUMA) begin
			luma_a = 64'(W_RED) * 64'(p.a_red) + 64'(W_GREEN) * 64'(p.a_green)
				+ 64'(W_BLUE) * 64'(p.a_blue);
			luma_b = 64'(W_RED) * 64'(p.b_red) + 64'(W_GREEN) * 64'(p.b_green)
				+ 64'(W_BLUE) * 64'(p.b_blue);
			luma_diff = (luma_a >= luma_b) ? luma_a - luma_b : luma_b - luma_a;
			return (luma_diff * luma_diff) >> 24;
		end
		db = 64'((p.a_blue >= p.b_blue) ? p.a_blue - p.b_blue : p.b_blue - p.a_blue);
		dg = 64'((p.a_green >= p.b_green) ? p.a_green - p.b_green : p.b_green - p.a_green);
		dr = 64'((p.a_red >= p.b_red) ? p.a_red - p.b_red : p.b_red - p.a_red);
		return (db * db + dg * dg + dr * dr) << 8;
	endfunction

	// Update the frame total for an accepted pair. The total clamps at the
	// 48-bit maximum; no frame in this run is long enough to get there, but the
	// clamp keeps the prediction faithful regardless.
	function automatic void accumulate_pair(input pixel_pair_t p);
		logic [63:0] sum;
		sum = frame_total + pair_term(p, luma_selected);
		if (sum > DISTANCE_MAX)
			sum = DISTANCE_MAX;
		pairs_sent++;
		if (p.last) begin
			expected_distances = {expected_distances, sum[47:0]};
			frame_total = '0;
			frames_sent++;
			if (luma_selected == MODE_LUMA)
				luma_frames++;
		end else begin
			frame_total = sum;
		end
	endfunction

	function automatic pixel_pair_t make_pair(input logic [7:0] ab, input logic [7:0] ag,
			input logic [7:0] ar, input logic [7:0] bb, input logic [7:0] bg,
			input logic [7:0] br, input logic last);
		pixel_pair_t p;
		p.a_blue  = ab;
		p.a_green = ag;
		p.a_red   = ar;
		p.b_blue  = bb;
		p.b_green = bg;
		p.b_red   = br;
		p.last    = last;
		return p;
	endfunction

	// Mostly uniform bytes, some pairs with every byte at an extreme, and some
	// nearly equal pixels so that small luma differences hit the truncation.
	function automatic pixel_pair_t random_pair();
		pixel_pair_t p;
		int unsigned flavor;
		flavor = $urandom_range(0, 9);
		p = make_pair(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 1'b0);
		if (flavor < 2) begin
			p.a_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			p.a_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			p.a_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			p.b_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			p.b_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			p.b_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end else if (flavor < 5) begin
			p.b_blue  = p.a_blue ^ 8'($urandom_range(0, 3));
			p.b_green = p.a_green ^ 8'($urandom_range(0, 3));
			p.b_red   = p.a_red ^ 8'($urandom_range(0, 3));
		end
		return p;
	endfunction

	// Send one pixel pair. Valid stays high from one transfer to the next when
	// no gap is drawn; the prediction is updated at the accepting edge.
	task automatic send_pair(input pixel_pair_t p);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		a_blue     <= p.a_blue;
		a_green    <= p.a_green;
		a_red      <= p.a_red;
		b_blue     <= p.b_blue;
		b_green    <= p.b_green;
		b_red      <= p.b_red;
		last_pixel <= p.last;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		accumulate_pair(p);
	endtask

	// Stop sending, wait for every owed distance, then give the pipeline time
	// to absorb pairs of an unfinished frame, which produce no result.
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_distances.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The mode is only changed with the block drained.
	task automatic set_mode(input bit mode);
		drain_block();
		@(negedge clk);
		cfg_data  <= mode;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		luma_selected = mode;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Runs in the mode left by reset, so it also checks the register's reset value.
	task automatic test_rgb_extremes();
		send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		send_pair(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1));
		send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		// Each channel on its own at full swing.
		send_pair(make_pair(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		send_pair(make_pair(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1));
		// A short frame: maximal terms around a random pair.
		send_pair(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
		send_pair(random_pair());
		send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1));
	endtask

	task automatic test_luma_extremes();
		set_mode(MODE_LUMA);
		send_pair(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1));
		send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		send_pair(make_pair(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 1'b1));
		// One-step differences in a single channel, where truncation matters.
		send_pair(make_pair(8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1));
		send_pair(make_pair(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		// Colors differ at full swing in more than one channel.
		send_pair(make_pair(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0));
		send_pair(make_pair(8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1));
	endtask

	// A mode change inside a frame applies from the next pair on and keeps the
	// terms already added.
	task automatic test_mode_change_in_frame();
		send_pair(random_pair());
		send_pair(random_pair());
		set_mode(MODE_RGB);
		send_pair(random_pair());
		send_pair(make_pair(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1));
		send_pair(random_pair());
		set_mode(MODE_LUMA);
		send_pair(random_pair());
		send_pair(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1));
	endtask

	// Random frames, mostly short with some long ones, in random modes, with
	// occasional mode changes inside a frame and bursts without any idling.
	task automatic test_random_frames();
		int unsigned target;
		int unsigned frame_len;
		int unsigned switch_at;
		pixel_pair_t p;
		target = pairs_sent + RANDOM_PAIRS;
		while (pairs_sent < target) begin
			if ($urandom_range(0, 3) == 0)
				set_mode($urandom_range(0, 1) ? MODE_LUMA : MODE_RGB);
			no_idle = ($urandom_range(0, 4) == 0);
			frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
				: $urandom_range(1, 12);
			switch_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, frame_len)
				: frame_len;
			for (int unsigned i = 0; i < frame_len; i++) begin
				if (i == switch_at)
					set_mode(luma_selected == MODE_LUMA ? MODE_RGB : MODE_LUMA);
				p = random_pair();
				p.last = (i == frame_len - 1);
				send_pair(p);
			end
		end
		no_idle = 1'b0;
	endtask

	// Receiver: for each result draw a random stall, then take it.
	initial begin : result_receiver
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 5);
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Result checker and watchdog. The watchdog counts clocks in which no
	// transfer happens on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_distances.size() == 0) begin
					$display("%0t: distance %0d arrived with none expected", $time, distance);
					error_count++;
				end else begin
					wanted_distance = expected_distances.pop_front();
					distances_checked++;
					if (distance !== wanted_distance) begin
						$display("%0t: distance mismatch, expected %0d, got %0d",
							$time, wanted_distance, distance);
						error_count++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d distances outstanding",
					$time, quiet_cycles, expected_distances.size());
				$display("tb_frame_sum_squared_difference NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = 1'b0;
		in_valid   = 1'b0;
		a_blue     = '0;
		a_green    = '0;
		a_red      = '0;
		b_blue     = '0;
		b_green    = '0;
		b_red      = '0;
		last_pixel = 1'b0;
		out_stall  = 1'b0;
		no_idle    = 1'b0;
		luma_selected = MODE_RGB;
		frame_total   = '0;
		pairs_sent = 0;
		frames_sent = 0;
		luma_frames = 0;
		distances_checked = 0;
		error_count = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_rgb_extremes();
		test_luma_extremes();
		test_mode_change_in_frame();
		test_random_frames();
		// Leave the register at its reset setting, written explicitly.
		set_mode(MODE_RGB);
		drain_block();

		if (expected_distances.size() != 0) begin
			$display("%0t: %0d distances never arrived", $time, expected_distances.size());
			error_count++;
		end
		$display("Sent %0d pixel pairs in %0d frames, %0d of them in luminance mode.",
			pairs_sent, frames_sent, luma_frames);
		$display("Checked %0d distances, %0d errors.", distances_checked, error_count);
		if (error_count == 0)
			$display("tb_frame_sum_squared_difference OK");
		else
			$display("tb_frame_sum_squared_difference NOT OK");
		$finish;
	end

endmodule
